// ===== rtl/core/mbec_pkg.sv =====
// shared types and constants for the mouse button event corrector
`default_nettype none

package mbec_pkg;

  // default widths of the event fields
  localparam int COORD_WIDTH_DEF = 12;
  localparam int TIME_WIDTH_DEF  = 32;

  // fixed widths
  localparam int MODS_W       = 3;
  localparam int STALE_TIME_W = 16;
  localparam int STALE_DIST_W = 12;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;
  // compare width for distances, covers coordinate widths up to 16 bits and the limit
  localparam int DIST_CMP_W   = 16;

  // configuration reset values
  localparam logic [STALE_TIME_W-1:0] STALE_TIME_RST = 16'd750;
  localparam logic [STALE_DIST_W-1:0] STALE_DIST_RST = 12'd4;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STALE_TIME = 1'b0,
    CFG_STALE_DIST = 1'b1
  } mbec_cfg_reg_t;

  // button 1 tracking state
  typedef enum logic [1:0] {
    TRK_IDLE = 2'd0,
    TRK_HELD = 2'd1,
    TRK_PROV = 2'd2
  } mbec_track_t;

  // current configuration
  typedef struct packed {
    logic [STALE_TIME_W-1:0] stale_time;
    logic [STALE_DIST_W-1:0] stale_dist;
  } mbec_cfg_t;

  // corrected flags and state after one item
  typedef struct packed {
    logic        press;
    logic        rel;
    logic        motion;
    mbec_track_t state;
  } mbec_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/mbec_in_if.sv =====
// input event channel
`default_nettype none

interface mbec_in_if #(
  parameter int COORD_WIDTH = mbec_pkg::COORD_WIDTH_DEF,
  parameter int TIME_WIDTH  = mbec_pkg::TIME_WIDTH_DEF
) ();
  logic                      valid;
  logic                      ready;
  logic                      press_flag;
  logic                      release_flag;
  logic                      motion_flag;
  logic [mbec_pkg::MODS_W-1:0] modifier_bits;
  logic [COORD_WIDTH-1:0]    cursor_col;
  logic [COORD_WIDTH-1:0]    cursor_row;
  logic [TIME_WIDTH-1:0]     time_ms;

  modport source (
    output valid, press_flag, release_flag, motion_flag, modifier_bits,
           cursor_col, cursor_row, time_ms,
    input  ready
  );

  modport sink (
    input  valid, press_flag, release_flag, motion_flag, modifier_bits,
           cursor_col, cursor_row, time_ms,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/mbec_out_if.sv =====
// corrected event channel
`default_nettype none

interface mbec_out_if #(
  parameter int COORD_WIDTH = mbec_pkg::COORD_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic                        out_press;
  logic                        out_release;
  logic                        out_motion;
  logic [mbec_pkg::MODS_W-1:0] out_modifiers;
  logic [COORD_WIDTH-1:0]      out_col;
  logic [COORD_WIDTH-1:0]      out_row;
  logic [1:0]                  track_state;

  modport source (
    output valid, out_press, out_release, out_motion, out_modifiers,
           out_col, out_row, track_state,
    input  ready
  );

  modport sink (
    input  valid, out_press, out_release, out_motion, out_modifiers,
           out_col, out_row, track_state,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/mbec_cfg_regs.sv =====
// configuration registers for the stale limits
`default_nettype none

module mbec_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [mbec_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [mbec_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output mbec_pkg::mbec_cfg_t                      cfg
);

  logic [mbec_pkg::STALE_TIME_W-1:0] stale_time_r, stale_time_nxt;
  logic [mbec_pkg::STALE_DIST_W-1:0] stale_dist_r, stale_dist_nxt;

  // register write decode
  always_comb begin
    stale_time_nxt = stale_time_r;
    stale_dist_nxt = stale_dist_r;
    if (cfg_we) begin
      case (mbec_pkg::mbec_cfg_reg_t'(cfg_index))
        mbec_pkg::CFG_STALE_TIME: stale_time_nxt = cfg_wdata[mbec_pkg::STALE_TIME_W-1:0];
        mbec_pkg::CFG_STALE_DIST: stale_dist_nxt = cfg_wdata[mbec_pkg::STALE_DIST_W-1:0];
        default: begin
          stale_time_nxt = stale_time_r;
          stale_dist_nxt = stale_dist_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_time_r <= mbec_pkg::STALE_TIME_RST;
      stale_dist_r <= mbec_pkg::STALE_DIST_RST;
    end else begin
      stale_time_r <= stale_time_nxt;
      stale_dist_r <= stale_dist_nxt;
    end
  end

  assign cfg.stale_time = stale_time_r;
  assign cfg.stale_dist = stale_dist_r;

endmodule

`default_nettype wire

// ===== rtl/core/mbec_in_reg.sv =====
// input register stage of the event pipeline
`default_nettype none

module mbec_in_reg #(
  parameter int COORD_WIDTH = mbec_pkg::COORD_WIDTH_DEF,
  parameter int TIME_WIDTH  = mbec_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  mbec_in_if.sink                            in_ch,
  input  wire logic                          advance,
  output logic                               item_valid,
  output logic                               press_flag,
  output logic                               release_flag,
  output logic                               motion_flag,
  output logic [mbec_pkg::MODS_W-1:0]        modifier_bits,
  output logic [COORD_WIDTH-1:0]             cursor_col,
  output logic [COORD_WIDTH-1:0]             cursor_row,
  output logic [TIME_WIDTH-1:0]              time_ms
);

  logic                        valid_r, valid_nxt;
  logic                        press_r, release_r, motion_r;
  logic [mbec_pkg::MODS_W-1:0] mods_r;
  logic [COORD_WIDTH-1:0]      col_r, row_r;
  logic [TIME_WIDTH-1:0]       time_r;
  logic                        load;

  // take a new item when empty or when the held one moves on
  assign in_ch.ready = !valid_r || advance;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      press_r   <= in_ch.press_flag;
      release_r <= in_ch.release_flag;
      motion_r  <= in_ch.motion_flag;
      mods_r    <= in_ch.modifier_bits;
      col_r     <= in_ch.cursor_col;
      row_r     <= in_ch.cursor_row;
      time_r    <= in_ch.time_ms;
    end
  end

  assign item_valid    = valid_r;
  assign press_flag    = press_r;
  assign release_flag  = release_r;
  assign motion_flag   = motion_r;
  assign modifier_bits = mods_r;
  assign cursor_col    = col_r;
  assign cursor_row    = row_r;
  assign time_ms       = time_r;

endmodule

`default_nettype wire

// ===== rtl/core/mbec_tracker.sv =====
// button 1 tracking state and press/release correction
`default_nettype none

module mbec_tracker #(
  parameter int COORD_WIDTH = mbec_pkg::COORD_WIDTH_DEF,
  parameter int TIME_WIDTH  = mbec_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   fire,
  input  wire mbec_pkg::mbec_cfg_t    cfg,
  input  wire logic                   press_flag,
  input  wire logic                   release_flag,
  input  wire logic                   motion_flag,
  input  wire logic [COORD_WIDTH-1:0] cursor_col,
  input  wire logic [COORD_WIDTH-1:0] cursor_row,
  input  wire logic [TIME_WIDTH-1:0]  time_ms,
  output mbec_pkg::mbec_flags_t       flags
);

  mbec_pkg::mbec_track_t  track_r, track_nxt;
  logic [TIME_WIDTH-1:0]  last_time_r;
  logic [COORD_WIDTH-1:0] last_col_r, last_row_r;
  logic                   pos_known_r;

  logic [TIME_WIDTH-1:0]  elapsed;
  logic [COORD_WIDTH-1:0] dx, dy;
  logic [mbec_pkg::DIST_CMP_W-1:0] dx_ext, dy_ext, lim_ext;
  logic                   time_over, moved, stale, capture;

  // stale test: wrapped elapsed time and cell move in either axis
  assign elapsed = time_ms - last_time_r;
  assign dx      = !pos_known_r ? '0 :
                   (cursor_col >= last_col_r) ? cursor_col - last_col_r
                                              : last_col_r - cursor_col;
  assign dy      = !pos_known_r ? '0 :
                   (cursor_row >= last_row_r) ? cursor_row - last_row_r
                                              : last_row_r - cursor_row;
  assign dx_ext    = mbec_pkg::DIST_CMP_W'(dx);
  assign dy_ext    = mbec_pkg::DIST_CMP_W'(dy);
  assign lim_ext   = mbec_pkg::DIST_CMP_W'(cfg.stale_dist);
  assign time_over = elapsed > TIME_WIDTH'(cfg.stale_time);
  assign moved     = (dx_ext >= lim_ext) || (dy_ext >= lim_ext);
  assign stale     = time_over && moved;

  // correction and next state
  always_comb begin
    track_nxt    = track_r;
    flags.press  = press_flag;
    flags.rel    = release_flag;
    flags.motion = motion_flag;
    capture      = 1'b0;
    if (release_flag) begin
      case (track_r)
        mbec_pkg::TRK_IDLE: begin
          flags.rel    = 1'b0;
          flags.motion = 1'b1;
        end
        mbec_pkg::TRK_HELD: begin
          if (stale) begin
            track_nxt    = mbec_pkg::TRK_PROV;
            flags.rel    = 1'b0;
            flags.motion = 1'b1;
          end else begin
            track_nxt = mbec_pkg::TRK_IDLE;
          end
        end
        default: begin
          // provisional release is confirmed
          track_nxt = mbec_pkg::TRK_IDLE;
        end
      endcase
    end else if (press_flag) begin
      capture   = 1'b1;
      track_nxt = mbec_pkg::TRK_HELD;
      if (track_r != mbec_pkg::TRK_IDLE) begin
        // press continues a drag
        flags.press  = 1'b0;
        flags.motion = 1'b1;
      end
    end
    flags.state = track_nxt;
  end

  // state update once the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r     <= mbec_pkg::TRK_IDLE;
      last_time_r <= '0;
      last_col_r  <= '0;
      last_row_r  <= '0;
      pos_known_r <= 1'b0;
    end else if (fire) begin
      track_r <= track_nxt;
      if (capture) begin
        last_time_r <= time_ms;
        last_col_r  <= cursor_col;
        last_row_r  <= cursor_row;
        pos_known_r <= 1'b1;
      end
    end
  end

  // state holds while no item goes through
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(track_r))
    else $error("tracking state changed without an item");

  // a passed release always leaves the button idle
  a_release_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && flags.rel |=> track_r == mbec_pkg::TRK_IDLE)
    else $error("passed release did not return to idle");

  // a passed press without release only comes out of idle
  a_press_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && flags.press && !release_flag |-> track_r == mbec_pkg::TRK_IDLE)
    else $error("press passed while button already down");

  // a press records the position
  a_press_records: assert property (@(posedge clk) disable iff (!rst_n)
    fire && press_flag && !release_flag |=> pos_known_r && last_time_r == $past(time_ms))
    else $error("press did not record time and position");

endmodule

`default_nettype wire

// ===== rtl/core/mbec_out_reg.sv =====
// result register driving the corrected event channel
`default_nettype none

module mbec_out_reg #(
  parameter int COORD_WIDTH = mbec_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          item_valid,
  input  wire mbec_pkg::mbec_flags_t         flags,
  input  wire logic [mbec_pkg::MODS_W-1:0]   modifier_bits,
  input  wire logic [COORD_WIDTH-1:0]        cursor_col,
  input  wire logic [COORD_WIDTH-1:0]        cursor_row,
  output logic                               advance,
  mbec_out_if.source                         out_ch
);

  logic                        valid_r, valid_nxt;
  mbec_pkg::mbec_flags_t       flags_r;
  logic [mbec_pkg::MODS_W-1:0] mods_r;
  logic [COORD_WIDTH-1:0]      col_r, row_r;
  logic                        load;

  // room for a new result when empty or when the current one is taken
  assign advance = !valid_r || out_ch.ready;
  assign load    = item_valid && advance;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      flags_r <= flags;
      mods_r  <= modifier_bits;
      col_r   <= cursor_col;
      row_r   <= cursor_row;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.out_press     = flags_r.press;
  assign out_ch.out_release   = flags_r.rel;
  assign out_ch.out_motion    = flags_r.motion;
  assign out_ch.out_modifiers = mods_r;
  assign out_ch.out_col       = col_r;
  assign out_ch.out_row       = row_r;
  assign out_ch.track_state   = flags_r.state;

endmodule

`default_nettype wire

// ===== rtl/core/mouse_button_event_corrector.sv =====
// top level of the mouse button 1 event corrector
//
// Each item on in_ch is one mouse event; each item on out_ch is the same
// event with the button 1 press/release flags corrected, the motion flag
// set where a press or release was rewritten, and the tracking state
// (0 idle, 1 held, 2 provisional) after the event. One result per event,
// in order. Both channels use valid/ready.
// The stale limits are written through cfg_we/cfg_index/cfg_wdata
// (index 0: stale time in ms, index 1: stale distance in cells); the
// user must write them only while no event is in flight, and the block
// does not enforce this. An accepted event is held in the input
// register and then loaded into the result register, where out_ch takes it.
// Throughput: one event per cycle while out_ch is ready; the tracking state
// is updated in the same cycle that the event enters the result register.
// Reset (rst_n low, synchronous) empties both stages, returns the button
// to idle, clears the recorded press and loads the default limits.
// When out_ch stalls, the result register holds and the input register
// still takes one more event; in_ch.ready drops only when both are full.
`default_nettype none

module mouse_button_event_corrector #(
  parameter int COORD_WIDTH = mbec_pkg::COORD_WIDTH_DEF,
  parameter int TIME_WIDTH  = mbec_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  mbec_in_if.sink                                in_ch,
  mbec_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [mbec_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mbec_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  mbec_pkg::mbec_cfg_t         cfg;
  mbec_pkg::mbec_flags_t       flags;
  logic                        item_valid, advance, fire;
  logic                        press_flag, release_flag, motion_flag;
  logic [mbec_pkg::MODS_W-1:0] modifier_bits;
  logic [COORD_WIDTH-1:0]      cursor_col, cursor_row;
  logic [TIME_WIDTH-1:0]       time_ms;

  // an item moves from the input register to the result register
  assign fire = item_valid && advance;

  mbec_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mbec_in_reg #(
    .COORD_WIDTH (COORD_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .advance       (advance),
    .item_valid    (item_valid),
    .press_flag    (press_flag),
    .release_flag  (release_flag),
    .motion_flag   (motion_flag),
    .modifier_bits (modifier_bits),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .time_ms       (time_ms)
  );

  mbec_tracker #(
    .COORD_WIDTH (COORD_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .cfg          (cfg),
    .press_flag   (press_flag),
    .release_flag (release_flag),
    .motion_flag  (motion_flag),
    .cursor_col   (cursor_col),
    .cursor_row   (cursor_row),
    .time_ms      (time_ms),
    .flags        (flags)
  );

  mbec_out_reg #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .flags         (flags),
    .modifier_bits (modifier_bits),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .advance       (advance),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire

// ===== verif/mouse_button_event_corrector_tb.sv =====
// testbench for the mouse button event corrector: directed table, random phases, predictor
`timescale 1ns / 1ps

module mouse_button_event_corrector_tb;

  localparam int CW            = mbec_pkg::COORD_WIDTH_DEF;
  localparam int TW            = mbec_pkg::TIME_WIDTH_DEF;
  localparam int MW            = mbec_pkg::MODS_W;
  localparam int N_PHASES      = 6;
  localparam int PHASE_ITEMS   = 250;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 4;
  localparam int N_DIRECTED    = 23;

  // one mouse event as offered on the input channel
  typedef struct packed {
    logic            press;
    logic            rel;
    logic            motion;
    logic [MW-1:0]   mods;
    logic [CW-1:0]   col;
    logic [CW-1:0]   row;
    logic [TW-1:0]   tms;
  } mouse_event_t;

  // one corrected event as expected on the result channel
  typedef struct packed {
    mbec_pkg::mbec_flags_t flags;
    logic [MW-1:0]   mods;
    logic [CW-1:0]   col;
    logic [CW-1:0]   row;
  } corrected_event_t;

  // directed row: event plus corrected flags where they are obvious
  typedef struct packed {
    mouse_event_t          ev;
    logic                  typed;
    mbec_pkg::mbec_flags_t flags;
  } directed_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  mbec_pkg::mbec_cfg_reg_t         cfg_index;
  logic [mbec_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mbec_in_if  in_ch ();
  mbec_out_if out_ch ();

  mouse_button_event_corrector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // tracker copy: limits, button state and recorded press
  mbec_pkg::mbec_cfg_t   limits;
  mbec_pkg::mbec_track_t trk;
  logic [TW-1:0] down_time;
  logic [CW-1:0] down_col;
  logic [CW-1:0] down_row;
  logic          pos_known;

  corrected_event_t expected_q [$];

  int err_count       = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_req        = 0;
  int quiet_cycles    = 0;

  // random event generator state
  logic [TW-1:0] gen_clock;
  logic [TW-1:0] gen_press_time;
  logic [CW-1:0] anchor_col;
  logic [CW-1:0] anchor_row;

  // directed events, starting from reset limits 750 ms and 4 cells
  directed_row_t directed_rows [N_DIRECTED] = '{
    // release while idle
    '{'{1'b0, 1'b1, 1'b0, 3'd0, 12'd0, 12'd0, 32'd0},
      1'b1, '{1'b0, 1'b0, 1'b1, mbec_pkg::TRK_IDLE}},
    // press and release together while idle, press passes through
    '{'{1'b1, 1'b1, 1'b0, 3'd7, 12'd4095, 12'd4095, 32'hFFFF_FFFF},
      1'b1, '{1'b1, 1'b0, 1'b1, mbec_pkg::TRK_IDLE}},
    '{'{1'b1, 1'b0, 1'b0, 3'd3, 12'd100, 12'd100, 32'd1000},
      1'b1, '{1'b1, 1'b0, 1'b0, mbec_pkg::TRK_HELD}},
    // drag press while held
    '{'{1'b1, 1'b0, 1'b1, 3'd0, 12'd101, 12'd100, 32'd1010},
      1'b1, '{1'b0, 1'b0, 1'b1, mbec_pkg::TRK_HELD}},
    '{'{1'b0, 1'b1, 1'b0, 3'd0, 12'd101, 12'd100, 32'd1020},
      1'b1, '{1'b0, 1'b1, 1'b0, mbec_pkg::TRK_IDLE}},
    '{'{1'b1, 1'b0, 1'b0, 3'd1, 12'd200, 12'd200, 32'd5000},
      1'b1, '{1'b1, 1'b0, 1'b0, mbec_pkg::TRK_HELD}},
    // stale release, time just over and distance just at the limit
    '{'{1'b0, 1'b1, 1'b0, 3'd2, 12'd204, 12'd200, 32'd5751},
      1'b1, '{1'b0, 1'b0, 1'b1, mbec_pkg::TRK_PROV}},
    // release confirms a provisional release
    '{'{1'b0, 1'b1, 1'b0, 3'd4, 12'd204, 12'd200, 32'd5800},
      1'b1, '{1'b0, 1'b1, 1'b0, mbec_pkg::TRK_IDLE}},
    '{'{1'b1, 1'b0, 1'b0, 3'd0, 12'd300, 12'd300, 32'd6000},
      1'b1, '{1'b1, 1'b0, 1'b0, mbec_pkg::TRK_HELD}},
    // late but moved one cell short of the limit
    '{'{1'b0, 1'b1, 1'b0, 3'd0, 12'd300, 12'd303, 32'd6751},
      1'b1, '{1'b0, 1'b1, 1'b0, mbec_pkg::TRK_IDLE}},
    '{'{1'b1, 1'b0, 1'b0, 3'd0, 12'd10, 12'd10, 32'd7000},
      1'b1, '{1'b1, 1'b0, 1'b0, mbec_pkg::TRK_HELD}},
    // moved far but elapsed exactly at the limit
    '{'{1'b0, 1'b1, 1'b0, 3'd0, 12'd20, 12'd10, 32'd7750},
      1'b1, '{1'b0, 1'b1, 1'b0, mbec_pkg::TRK_IDLE}},
    '{'{1'b1, 1'b0, 1'b0, 3'd0, 12'd50, 12'd50, 32'd8000},
      1'b1, '{1'b1, 1'b0, 1'b0, mbec_pkg::TRK_HELD}},
    // stale by row
    '{'{1'b0, 1'b1, 1'b0, 3'd0, 12'd50, 12'd54, 32'd9000},
      1'b1, '{1'b0, 1'b0, 1'b1, mbec_pkg::TRK_PROV}},
    // press resumes the drag from provisional
    '{'{1'b1, 1'b0, 1'b0, 3'd5, 12'd4095, 12'd4095, 32'hFFFF_FF00},
      1'b1, '{1'b0, 1'b0, 1'b1, mbec_pkg::TRK_HELD}},
    // plain motion and empty events pass unchanged
    '{'{1'b0, 1'b0, 1'b1, 3'd5, 12'd4095, 12'd0, 32'hFFFF_FF10},
      1'b1, '{1'b0, 1'b0, 1'b1, mbec_pkg::TRK_HELD}},
    '{'{1'b0, 1'b0, 1'b0, 3'd7, 12'd0, 12'd4095, 32'd5},
      1'b1, '{1'b0, 1'b0, 1'b0, mbec_pkg::TRK_HELD}},
    // elapsed time across the timestamp wrap
    '{'{1'b0, 1'b1, 1'b0, 3'd6, 12'd0, 12'd4095, 32'h0000_0400},
      1'b0, '{1'b0, 1'b0, 1'b0, mbec_pkg::TRK_IDLE}},
    '{'{1'b0, 1'b1, 1'b1, 3'd0, 12'd4095, 12'd0, 32'h0000_0410},
      1'b1, '{1'b0, 1'b1, 1'b1, mbec_pkg::TRK_IDLE}},
    '{'{1'b1, 1'b0, 1'b0, 3'd0, 12'd2048, 12'd2048, 32'd100},
      1'b1, '{1'b1, 1'b0, 1'b0, mbec_pkg::TRK_HELD}},
    // timestamp going backwards, huge wrapped elapsed, no move
    '{'{1'b0, 1'b1, 1'b0, 3'd0, 12'd2048, 12'd2048, 32'd50},
      1'b0, '{1'b0, 1'b0, 1'b0, mbec_pkg::TRK_IDLE}},
    '{'{1'b1, 1'b0, 1'b0, 3'd0, 12'd2000, 12'd2000, 32'd200},
      1'b0, '{1'b0, 1'b0, 1'b0, mbec_pkg::TRK_IDLE}},
    // both flags while held
    '{'{1'b1, 1'b1, 1'b0, 3'd0, 12'd2000, 12'd2000, 32'd2100},
      1'b0, '{1'b0, 1'b0, 1'b0, mbec_pkg::TRK_IDLE}}
  };

  function automatic logic [CW-1:0] cell_dist(logic [CW-1:0] a, logic [CW-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // late press and cursor jumped in either axis
  function automatic logic release_is_stale(mouse_event_t ev);
    logic [TW-1:0] elapsed;
    logic [CW-1:0] dx;
    logic [CW-1:0] dy;
    elapsed = ev.tms - down_time;
    dx = pos_known ? cell_dist(ev.col, down_col) : '0;
    dy = pos_known ? cell_dist(ev.row, down_row) : '0;
    return (elapsed > TW'(limits.stale_time)) &&
           (dx >= limits.stale_dist || dy >= limits.stale_dist);
  endfunction

  // corrects one event and advances the tracker
  function automatic corrected_event_t correct_event(mouse_event_t ev);
    corrected_event_t r;
    r.flags.press  = ev.press;
    r.flags.rel    = ev.rel;
    r.flags.motion = ev.motion;
    r.mods = ev.mods;
    r.col  = ev.col;
    r.row  = ev.row;
    if (ev.rel) begin
      case (trk)
        mbec_pkg::TRK_IDLE: begin
          r.flags.rel    = 1'b0;
          r.flags.motion = 1'b1;
        end
        mbec_pkg::TRK_HELD: begin
          if (release_is_stale(ev)) begin
            trk            = mbec_pkg::TRK_PROV;
            r.flags.rel    = 1'b0;
            r.flags.motion = 1'b1;
          end else begin
            trk = mbec_pkg::TRK_IDLE;
          end
        end
        default: trk = mbec_pkg::TRK_IDLE;
      endcase
    end else if (ev.press) begin
      if (trk != mbec_pkg::TRK_IDLE) begin
        r.flags.press  = 1'b0;
        r.flags.motion = 1'b1;
      end
      trk       = mbec_pkg::TRK_HELD;
      down_time = ev.tms;
      down_col  = ev.col;
      down_row  = ev.row;
      pos_known = 1'b1;
    end
    r.flags.state = trk;
    return r;
  endfunction

  // cell near the last press, at the distance limit, at an edge or anywhere
  function automatic logic [CW-1:0] pick_cell(logic [CW-1:0] anchor);
    int off;
    int c;
    case ($urandom_range(9))
      0, 1: return CW'($urandom);
      2: return $urandom_range(1) ? '0 : '1;
      default: begin
        case ($urandom_range(3))
          0: off = 0;
          1: off = int'(limits.stale_dist) - 1;
          2: off = int'(limits.stale_dist);
          default: off = $urandom_range(8);
        endcase
        if ($urandom_range(1)) off = -off;
        c = int'(anchor) + off;
        if (c < 0) c = 0;
        if (c > (1 << CW) - 1) c = (1 << CW) - 1;
        return CW'(c);
      end
    endcase
  endfunction

  // mostly press / drag / release sequences, some raw flag combinations
  function automatic mouse_event_t random_event();
    mouse_event_t ev;
    int kind;
    kind = $urandom_range(99);
    ev.press  = (kind < 40);
    ev.rel    = (kind >= 40 && kind < 78);
    ev.motion = 1'($urandom_range(1));
    if (kind >= 92) {ev.press, ev.rel, ev.motion} = 3'($urandom_range(7));
    ev.mods = MW'($urandom_range(7));
    case ($urandom_range(9))
      0, 1, 2, 3: gen_clock = gen_clock + $urandom_range(50);
      4, 5, 6: gen_clock = gen_press_time + limits.stale_time + $urandom_range(2) - 1;
      7: gen_clock = gen_clock + $urandom_range(200000);
      8: gen_clock = $urandom;
      default: ;
    endcase
    ev.tms = gen_clock;
    ev.col = pick_cell(anchor_col);
    ev.row = pick_cell(anchor_row);
    if (ev.press && !ev.rel) begin
      anchor_col     = ev.col;
      anchor_row     = ev.row;
      gen_press_time = ev.tms;
    end
    return ev;
  endfunction

  // offer one item, with random idle cycles first, until it is taken
  task automatic drive_event(mouse_event_t ev);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.press_flag    <= ev.press;
    in_ch.release_flag  <= ev.rel;
    in_ch.motion_flag   <= ev.motion;
    in_ch.modifier_bits <= ev.mods;
    in_ch.cursor_col    <= ev.col;
    in_ch.cursor_row    <= ev.row;
    in_ch.time_ms       <= ev.tms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop offering until every result is out, then let the pipe go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both limits, junk above the distance field
  task automatic write_limits(logic [mbec_pkg::STALE_TIME_W-1:0] t,
                              logic [mbec_pkg::STALE_DIST_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= mbec_pkg::CFG_STALE_TIME;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_index <= mbec_pkg::CFG_STALE_DIST;
    cfg_wdata <= mbec_pkg::CFG_DATA_W'({$urandom_range(15), d});
    @(posedge clk);
    cfg_we <= 1'b0;
    limits.stale_time = t;
    limits.stale_dist = d;
  endtask

  task automatic check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result channel: random stalls plus long hold-offs on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_req) begin
        hold_seen    = hold_req;
        hold_left    = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    corrected_event_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none actual col %0h row %0h",
                 $time, out_ch.out_col, out_ch.out_row);
      end else begin
        want = expected_q.pop_front();
        check_field("out_press", want.flags.press, out_ch.out_press);
        check_field("out_release", want.flags.rel, out_ch.out_release);
        check_field("out_motion", want.flags.motion, out_ch.out_motion);
        check_field("out_modifiers", want.mods, out_ch.out_modifiers);
        check_field("out_col", want.col, out_ch.out_col);
        check_field("out_row", want.row, out_ch.out_row);
        check_field("track_state", want.flags.state, out_ch.track_state);
      end
    end
  end

  // watchdog on cycles where no item moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus: reset, directed table, then random phases
  initial begin : stimulus
    directed_row_t    dir_row;
    corrected_event_t want;
    mouse_event_t     ev;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = mbec_pkg::CFG_STALE_TIME;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.press_flag    = 1'b0;
    in_ch.release_flag  = 1'b0;
    in_ch.motion_flag   = 1'b0;
    in_ch.modifier_bits = '0;
    in_ch.cursor_col    = '0;
    in_ch.cursor_row    = '0;
    in_ch.time_ms       = '0;
    limits.stale_time   = mbec_pkg::STALE_TIME_RST;
    limits.stale_dist   = mbec_pkg::STALE_DIST_RST;
    trk                 = mbec_pkg::TRK_IDLE;
    down_time           = '0;
    down_col            = '0;
    down_row            = '0;
    pos_known           = 1'b0;
    gen_clock           = '0;
    gen_press_time      = '0;
    anchor_col          = CW'(1 << (CW - 1));
    anchor_row          = CW'(1 << (CW - 1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, typed flags override the tracker where given
    foreach (directed_rows[i]) begin
      dir_row = directed_rows[i];
      drive_event(dir_row.ev);
      want = correct_event(dir_row.ev);
      if (dir_row.typed) want.flags = dir_row.flags;
      expected_q.push_back(want);
    end
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: write_limits(mbec_pkg::STALE_TIME_RST, mbec_pkg::STALE_DIST_RST);
        1: write_limits('0, '0);
        2: write_limits('1, '1);
        3: write_limits('0, '1);
        4: write_limits('1, '0);
        default: write_limits(mbec_pkg::STALE_TIME_W'($urandom_range(65535)),
                              mbec_pkg::STALE_DIST_W'($urandom_range(4095)));
      endcase
      // idling mode: none, sender, receiver, both
      case (p % 4)
        1: begin
          sender_idle_pct = 60;
          recv_stall_pct  <= 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  <= 60;
        end
        3: begin
          sender_idle_pct = 17;
          recv_stall_pct  <= 17;
        end
        default: begin
          sender_idle_pct = 0;
          recv_stall_pct  <= 0;
        end
      endcase
      // receiver holds off while the sender keeps offering
      if (p % 4 == 0) hold_req <= hold_req + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) settle();
        ev = random_event();
        drive_event(ev);
        expected_q.push_back(correct_event(ev));
      end
      settle();
    end

    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
